// ===== src/sobel_pkg.sv =====
// Shared types and constants for the RGB Sobel gradient magnitude block.
package sobel_pkg;

  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int HEIGHT_LIMIT      = 8192;
  localparam int WIDTH_RESET       = 640;
  localparam int HEIGHT_RESET      = 480;
  localparam int ROW_W             = 14;
  localparam int CFG_W             = 14;
  localparam int CFG_IDX_W         = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

  localparam logic [7:0] SATURATE = 8'd255;
  localparam logic [21:0] SAT_LIMIT = 22'd65281;

  // One packed pixel: red in [7:0], green in [15:8], blue in [23:16].
  typedef logic [23:0] pix_t;

  // 3x3 neighborhood, [row top..bottom][column left..right].
  typedef pix_t [2:0][2:0] win_t;

  typedef struct packed {
    logic       func;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0] edge_red;
    logic [7:0] edge_green;
    logic [7:0] edge_blue;
    logic       frame_last;
  } out_word_t;

  // Work handed from the front end to the back end.
  typedef struct packed {
    win_t win;
    logic last;
  } job_t;

endpackage

// ===== src/sobel_front.sv =====
// Front end: accepts words, keeps line stores and window, and issues windows to evaluate.
module sobel_front #(
  parameter int MAX_WIDTH = sobel_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [sobel_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sobel_pkg::CFG_W-1:0]        cfg_data,
  input  logic                               pixel_valid,
  output logic                               pixel_stall,
  input  sobel_pkg::in_word_t                pixel,
  input  logic                               q_full,
  output logic                               q_push,
  output sobel_pkg::job_t                    q_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int WD_RST = (sobel_pkg::WIDTH_RESET > MAX_WIDTH) ?
                          MAX_WIDTH : sobel_pkg::WIDTH_RESET;
  localparam int RW = sobel_pkg::ROW_W;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_UPD  = 1'b1;

  logic                  fstate;
  logic [WW-1:0]         wd;
  logic [RW-1:0]         ht;
  logic [CW-1:0]         in_col, out_col, col_q;
  logic [RW-1:0]         in_row, out_row, row_q;
  sobel_pkg::pix_t       pix_q, up_rd, mid_rd, up_v, mid_v;
  sobel_pkg::win_t       win, win_next, eval;
  sobel_pkg::pix_t       upper [MAX_WIDTH];
  sobel_pkg::pix_t       middle [MAX_WIDTH];
  logic                  accept, ignore, emit, last, col_end;
  logic [31:0]           wv;
  logic [sobel_pkg::ROW_W-1:0] hv;

  assign accept      = pixel_valid && !pixel_stall;
  assign pixel_stall = (fstate != F_IDLE) || q_full;
  assign ignore      = pixel.func && (in_row < ht);

  // Row stores: read on acceptance, written in the update cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      up_rd  <= upper[in_col];
      mid_rd <= middle[in_col];
    end
  end

  always_ff @(posedge clk) begin
    if (fstate == F_UPD) begin
      upper[col_q]  <= mid_v;
      middle[col_q] <= pix_q;
    end
  end

  // Rows above the frame read as zero.
  always_comb begin
    up_v  = (row_q >= RW'(2)) ? up_rd : '0;
    mid_v = (row_q >= RW'(1)) ? mid_rd : '0;
  end

  // Window shift and the neighborhood handed to the back end.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
    end
    win_next[0][2] = up_v;
    win_next[1][2] = mid_v;
    win_next[2][2] = pix_q;
    for (int r = 0; r < 3; r++) begin
      if (col_q == '0) begin
        eval[r][0] = (wd >= WW'(2)) ? win[r][1] : '0;
        eval[r][1] = win[r][2];
        eval[r][2] = '0;
      end else begin
        eval[r][0] = (col_q == CW'(1)) ? '0 : win_next[r][0];
        eval[r][1] = win_next[r][1];
        eval[r][2] = win_next[r][2];
      end
    end
  end

  assign emit    = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
  assign last    = (32'(out_row) + 32'd1 >= 32'(ht)) && (32'(out_col) + 32'd1 >= 32'(wd));
  assign col_end = (32'(col_q) + 32'd1 >= 32'(wd));

  assign q_push      = (fstate == F_UPD) && emit;
  assign q_data.win  = eval;
  assign q_data.last = last;

  // Clamp incoming register values to their legal ranges.
  always_comb begin
    wv = 32'(cfg_data[10:0]);
    if (wv == 32'd0) begin
      wv = 32'd1;
    end else if (wv > 32'(MAX_WIDTH)) begin
      wv = 32'(MAX_WIDTH);
    end
    hv = cfg_data[13:0];
    if (hv == '0) begin
      hv = 14'd1;
    end else if (32'(hv) > 32'(sobel_pkg::HEIGHT_LIMIT)) begin
      hv = 14'(sobel_pkg::HEIGHT_LIMIT);
    end
  end

  // Control: configuration, counters and the accept-then-update sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      fstate  <= F_IDLE;
      wd      <= WW'(WD_RST);
      ht      <= RW'(sobel_pkg::HEIGHT_RESET);
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      win     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sobel_pkg::REG_WIDTH:  wd <= WW'(wv);
        sobel_pkg::REG_HEIGHT: ht <= hv;
        default: ;
      endcase
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      unique case (fstate)
        F_IDLE: begin
          if (accept && !ignore) begin
            pix_q  <= (!pixel.func && in_row < ht) ?
                      {pixel.in_blue, pixel.in_green, pixel.in_red} : '0;
            col_q  <= in_col;
            row_q  <= in_row;
            fstate <= F_UPD;
          end
        end
        F_UPD: begin
          win    <= win_next;
          fstate <= F_IDLE;
          if (emit && last) begin
            in_col  <= '0;
            in_row  <= '0;
            out_col <= '0;
            out_row <= '0;
          end else begin
            if (col_end) begin
              in_col <= '0;
              in_row <= row_q + RW'(1);
            end else begin
              in_col <= col_q + CW'(1);
            end
            if (emit) begin
              if (32'(out_col) + 32'd1 >= 32'(wd)) begin
                out_col <= '0;
                out_row <= out_row + RW'(1);
              end else begin
                out_col <= out_col + CW'(1);
              end
            end
          end
        end
        default: fstate <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== src/sobel_queue.sv =====
// Two-entry queue that carries windows from the front end to the back end.
module sobel_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sobel_pkg::job_t push_data,
  output logic            full,
  input  logic            pop,
  output sobel_pkg::job_t pop_data,
  output logic            empty
);

  sobel_pkg::job_t mem [2];
  logic            wr_ptr, rd_ptr;
  logic [1:0]      count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

// ===== src/sobel_back.sv =====
// Back end: gradients, squared magnitude, iterative rounded square root, result register.
module sobel_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  sobel_pkg::job_t      q_data,
  output logic                 result_valid,
  input  logic                 result_stall,
  output sobel_pkg::out_word_t result
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_GRAD = 3'd1;
  localparam logic [2:0] B_SQ   = 3'd2;
  localparam logic [2:0] B_ROOT = 3'd3;
  localparam logic [2:0] B_RND  = 3'd4;
  localparam logic [2:0] B_OUT  = 3'd5;

  logic [2:0]        bstate;
  sobel_pkg::win_t   win_q;
  logic              last_q;
  logic signed [11:0] gx [3];
  logic signed [11:0] gy [3];
  logic [21:0]       sq [3];
  logic [7:0]        root [3];
  logic [2:0]        step;
  logic [7:0]        trial [3];
  logic [7:0]        mag [3];
  logic              out_load;

  // Signed value of one channel at a window position.
  function automatic logic signed [11:0] chan(sobel_pkg::win_t w, int r, int c, int ch);
    return $signed({4'b0, w[r][c][8*ch +: 8]});
  endfunction

  // Square of a gradient, taken on its magnitude at full width.
  function automatic logic [21:0] square(logic signed [11:0] g);
    logic [10:0] a;
    a = g[11] ? 11'(-g) : 11'(g);
    return 22'(a) * 22'(a);
  endfunction

  assign q_pop    = (bstate == B_IDLE) && !q_empty;
  assign out_load = (bstate == B_OUT) && (!result_valid || !result_stall);

  // Trial root bit for this step, and the saturated magnitude.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      trial[ch] = root[ch] | (8'd1 << step);
      mag[ch]   = (sq[ch] >= sobel_pkg::SAT_LIMIT) ? sobel_pkg::SATURATE : root[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate       <= B_IDLE;
      result_valid <= 1'b0;
    end else begin
      // Result register: loaded from the last step, cleared once taken.
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (bstate)
        B_IDLE: begin
          if (!q_empty) begin
            win_q  <= q_data.win;
            last_q <= q_data.last;
            bstate <= B_GRAD;
          end
        end
        // Sobel X and Y responses per channel.
        B_GRAD: begin
          for (int ch = 0; ch < 3; ch++) begin
            gx[ch] <= (chan(win_q, 0, 2, ch) + 12'sd2 * chan(win_q, 1, 2, ch)
                       + chan(win_q, 2, 2, ch))
                    - (chan(win_q, 0, 0, ch) + 12'sd2 * chan(win_q, 1, 0, ch)
                       + chan(win_q, 2, 0, ch));
            gy[ch] <= (chan(win_q, 0, 0, ch) + 12'sd2 * chan(win_q, 0, 1, ch)
                       + chan(win_q, 0, 2, ch))
                    - (chan(win_q, 2, 0, ch) + 12'sd2 * chan(win_q, 2, 1, ch)
                       + chan(win_q, 2, 2, ch));
          end
          bstate <= B_SQ;
        end
        // Squared magnitude.
        B_SQ: begin
          for (int ch = 0; ch < 3; ch++) begin
            sq[ch]   <= square(gx[ch]) + square(gy[ch]);
            root[ch] <= '0;
          end
          step   <= 3'd7;
          bstate <= B_ROOT;
        end
        // One root bit per cycle, most significant first.
        B_ROOT: begin
          for (int ch = 0; ch < 3; ch++) begin
            if (22'(trial[ch]) * 22'(trial[ch]) <= sq[ch]) begin
              root[ch] <= trial[ch];
            end
          end
          if (step == 3'd0) begin
            bstate <= B_RND;
          end else begin
            step <= step - 3'd1;
          end
        end
        // Round to nearest: step up when above n*n + n.
        B_RND: begin
          for (int ch = 0; ch < 3; ch++) begin
            if (sq[ch] < sobel_pkg::SAT_LIMIT &&
                sq[ch] > 22'(root[ch]) * 22'(root[ch]) + 22'(root[ch])) begin
              root[ch] <= root[ch] + 8'd1;
            end
          end
          bstate <= B_OUT;
        end
        B_OUT: begin
          if (out_load) begin
            result.edge_red   <= mag[0];
            result.edge_green <= mag[1];
            result.edge_blue  <= mag[2];
            result.frame_last <= last_q;
            bstate            <= B_IDLE;
          end
        end
        default: bstate <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== src/sobel_gradient_magnitude_rgb.sv =====
// Top level of the streaming RGB Sobel gradient magnitude block.
// Pixels enter in raster order and each result word leaves one row plus one pixel
// later, also in raster order; after the last pixel of a frame, flush words
// (func = 1) push out the remaining results, the final one marked frame_last.
// The front end accepts a word, reads the row stores, then updates them and the
// window, stalling new words meanwhile; the back end works on one window at a time
// through an eight-step square root and takes the next only once its result is loaded.
// A two-entry queue between them lets either side stall on its own. Writing
// a register restarts the frame; line stores need no clearing after reset.
module sobel_gradient_magnitude_rgb #(
  parameter int MAX_WIDTH = sobel_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [sobel_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sobel_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            pixel_valid,
  output logic                            pixel_stall,
  input  sobel_pkg::in_word_t             pixel,
  output logic                            result_valid,
  input  logic                            result_stall,
  output sobel_pkg::out_word_t            result
);

  logic            q_push, q_full, q_pop, q_empty;
  sobel_pkg::job_t q_in, q_out;

  sobel_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
    .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  sobel_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .pop_data(q_out), .empty(q_empty)
  );

  sobel_back u_back (
    .clk(clk), .rst(rst),
    .q_empty(q_empty), .q_pop(q_pop), .q_data(q_out),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

endmodule
